FILE: rtl/tcsg_pkg.sv
// ----------------------------------------------------------------------------
// tcsg_pkg: shared types and constants of the teleop command safety gate
// Item and result layouts, item kinds, register indexes, gear and turn codes.
// ----------------------------------------------------------------------------
package tcsg_pkg;

  localparam int VelW     = 16;  // velocity fields
  localparam int IdW      = 32;  // command identifier
  localparam int LimW     = 15;  // standstill limit register
  localparam int GainW    = 16;  // velocity gain register, Q4.12
  localparam int GainFrac = 12;
  localparam int TmoW     = 16;  // watchdog timeout and counter
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [1:0] {
    FuncTel  = 2'd0,
    FuncCmd  = 2'd1,
    FuncTick = 2'd2
  } tcsg_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStandstill = 2'd0,
    CfgGain       = 2'd1,
    CfgTimeout    = 2'd2
  } tcsg_cfg_e;

  localparam logic [2:0] GearNone  = 3'd0;
  localparam logic [2:0] GearPark  = 3'd1;
  localparam logic [2:0] GearDrive = 3'd2;

  localparam logic [1:0] TurnOff = 2'd0;

  localparam logic [LimW-1:0]  StandstillRst = LimW'(10);
  localparam logic [GainW-1:0] GainRst       = GainW'(11378);
  localparam logic [TmoW-1:0]  TimeoutRst    = TmoW'(3000);

  typedef struct packed {
    logic [1:0]             func;
    logic                   tel_remote;
    logic signed [VelW-1:0] tel_velocity;
    logic [2:0]             gear_code;
    logic [1:0]             turn_code;
    logic [IdW-1:0]         cmd_id;
    logic                   cmd_engage;
    logic signed [VelW-1:0] cmd_velocity;
    logic [15:0]            cmd_brake;
    logic signed [15:0]     cmd_steering;
    logic                   cmd_uplink_button;
  } tcsg_in_t;

  typedef struct packed {
    logic [IdW-1:0]         out_id;
    logic                   out_engage;
    logic signed [VelW-1:0] out_velocity;
    logic [15:0]            out_brake;
    logic signed [15:0]     out_steering;
    logic [2:0]             out_gear;
    logic [1:0]             out_turn;
    logic                   out_uplink;
  } tcsg_out_t;

endpackage

FILE: rtl/tcsg_vel_scale.sv
// ----------------------------------------------------------------------------
// tcsg_vel_scale: velocity gain stage
// Multiplies the commanded velocity by the Q4.12 gain, rounds half up and
// saturates to the signed velocity range.
// ----------------------------------------------------------------------------
module tcsg_vel_scale
  import tcsg_pkg::*;
(
  input  logic signed [VelW-1:0] vel_i,
  input  logic [GainW-1:0]       gain_i,
  output logic signed [VelW-1:0] vel_o
);

  localparam int ProdW = VelW + GainW + 1;
  localparam int SumW  = ProdW + 1;
  localparam int QW    = SumW - GainFrac;
  localparam logic [SumW-1:0] RoundHalf = SumW'(1) << (GainFrac - 1);
  localparam logic [VelW-1:0] VelMax = {1'b0, {(VelW-1){1'b1}}};
  localparam logic [VelW-1:0] VelMin = {1'b1, {(VelW-1){1'b0}}};

  logic signed [GainW:0]    gain_s;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   sum;
  logic [QW-1:0]            quot;
  logic [QW-VelW:0]         upper;
  logic                     ovf;

  assign gain_s = $signed({1'b0, gain_i});
  assign prod   = vel_i * gain_s;
  assign sum    = $signed({prod[ProdW-1], prod}) + $signed(RoundHalf);
  // arithmetic shift gives the floor for both signs
  assign quot   = sum[SumW-1:GainFrac];
  assign upper  = quot[QW-1:VelW-1];
  assign ovf    = !((&upper) || (~|upper));

  always_comb begin
    if (ovf) begin
      vel_o = quot[QW-1] ? $signed(VelMin) : $signed(VelMax);
    end else begin
      vel_o = $signed(quot[VelW-1:0]);
    end
  end

endmodule

FILE: rtl/teleop_command_safety_gate.sv
// ----------------------------------------------------------------------------
// teleop_command_safety_gate: operator command gate with telemetry watchdog
// Stores telemetry, gates raw commands through edge and standstill interlocks
// and scales the velocity command; ticks drive the telemetry watchdog.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_data_i   (tcsg_in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (tcsg_out_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low: an item is held in the input register,
// and the gate logic plus gain multiplier update the state and the result
// register from it, so a result passes the input and then the output register.
// Reset is asynchronous and active low; it loads the register defaults.
// A stalled result holds the output register; only a command item with valid
// telemetry waits behind it, while all other items keep flowing.
// ----------------------------------------------------------------------------
module teleop_command_safety_gate
  import tcsg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcsg_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcsg_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CmpW = ((VelW > LimW) ? VelW : LimW) + 1;

  // configuration
  logic [LimW-1:0]  limit_q;
  logic [GainW-1:0] gain_q;
  logic [TmoW-1:0]  tmo_q;

  // input register
  logic     s1_valid_q;
  tcsg_in_t s1_q;

  // gate state
  logic                   tel_valid_q, tel_valid_d;
  logic                   seen_remote_q, seen_remote_d;
  logic signed [VelW-1:0] seen_vel_q, seen_vel_d;
  logic [1:0]             seen_turn_q, seen_turn_d;
  logic [2:0]             seen_gear_q, seen_gear_d;
  logic                   engage_q, engage_d;
  logic                   engage_prev_q, engage_prev_d;
  logic [2:0]             gear_q, gear_d;
  logic [2:0]             gear_prev_q, gear_prev_d;
  logic [1:0]             turn_q, turn_d;
  logic [1:0]             turn_prev_q, turn_prev_d;
  logic                   uplink_q, uplink_d;
  logic                   uplink_prev_q, uplink_prev_d;
  logic [TmoW-1:0]        wd_q, wd_d;

  logic                   out_valid_q;
  tcsg_out_t              out_q, out_d;

  logic                   is_cmd;
  logic                   gives_result;
  logic                   s1_adv;
  logic                   standstill;
  logic [TmoW-1:0]        wd_inc;
  logic signed [VelW-1:0] vel_scaled;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= StandstillRst;
      gain_q  <= GainRst;
      tmo_q   <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgStandstill: limit_q <= cfg_data_i[LimW-1:0];
        CfgGain:       gain_q  <= cfg_data_i[GainW-1:0];
        CfgTimeout:    tmo_q   <= cfg_data_i[TmoW-1:0];
        default: ;
      endcase
    end
  end

  // only a command with valid telemetry needs room in the output register
  assign is_cmd       = (s1_q.func == FuncCmd);
  assign gives_result = s1_valid_q && is_cmd && tel_valid_q;
  assign s1_adv       = s1_valid_q && (!gives_result || !out_valid_q || !out_stall_i);
  assign in_stall_o   = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
  end

  tcsg_vel_scale u_vel_scale (
    .vel_i  (s1_q.cmd_velocity),
    .gain_i (gain_q),
    .vel_o  (vel_scaled)
  );

  // negative velocities count as standstill too
  assign standstill = $signed(CmpW'(seen_vel_q)) < $signed({{(CmpW-LimW){1'b0}}, limit_q});
  assign wd_inc     = wd_q + TmoW'(1);

  always_comb begin
    tel_valid_d   = tel_valid_q;
    seen_remote_d = seen_remote_q;
    seen_vel_d    = seen_vel_q;
    seen_turn_d   = seen_turn_q;
    seen_gear_d   = seen_gear_q;
    engage_d      = engage_q;
    engage_prev_d = engage_prev_q;
    gear_d        = gear_q;
    gear_prev_d   = gear_prev_q;
    turn_d        = turn_q;
    turn_prev_d   = turn_prev_q;
    uplink_d      = uplink_q;
    uplink_prev_d = uplink_prev_q;
    wd_d          = wd_q;

    out_d.out_id       = s1_q.cmd_id;
    out_d.out_velocity = '0;
    out_d.out_brake    = '0;
    out_d.out_steering = '0;

    if (s1_adv) begin
      unique case (s1_q.func)
        FuncTel: begin
          wd_d = '0;
          if (!tel_valid_q) begin
            engage_d    = s1_q.tel_remote;
            gear_d      = s1_q.gear_code;
            turn_d      = s1_q.turn_code;
            tel_valid_d = 1'b1;
          end
          seen_remote_d = s1_q.tel_remote;
          seen_vel_d    = s1_q.tel_velocity;
          seen_turn_d   = s1_q.turn_code;
          seen_gear_d   = s1_q.gear_code;
        end
        FuncTick: begin
          wd_d = wd_inc;
          if (wd_inc >= tmo_q) begin
            wd_d = '0;
            if (tel_valid_q) begin
              tel_valid_d   = 1'b0;
              seen_remote_d = 1'b0;
              seen_vel_d    = '0;
              seen_gear_d   = GearNone;
              engage_d      = 1'b0;
              engage_prev_d = 1'b0;
              gear_d        = GearPark;
              gear_prev_d   = GearNone;
              turn_d        = TurnOff;
              turn_prev_d   = TurnOff;
              uplink_prev_d = 1'b0;
              uplink_d      = 1'b0;
            end
          end
        end
        FuncCmd: begin
          if (tel_valid_q) begin
            if (s1_q.cmd_engage && !engage_prev_q && standstill) begin
              engage_d = !engage_q;
            end
            engage_prev_d = s1_q.cmd_engage;

            if (seen_remote_q) begin
              out_d.out_velocity = vel_scaled;
              out_d.out_brake    = s1_q.cmd_brake;
              out_d.out_steering = s1_q.cmd_steering;

              // a refused request while moving is not remembered, so it retries
              if (s1_q.gear_code != GearNone && s1_q.gear_code != gear_prev_q) begin
                if (standstill) begin
                  if (seen_gear_q == GearPark) begin
                    if (s1_q.gear_code == GearPark) begin
                      gear_d = GearDrive;
                    end
                  end else begin
                    gear_d = s1_q.gear_code;
                  end
                  gear_prev_d = s1_q.gear_code;
                end
              end else if (s1_q.gear_code == GearNone) begin
                gear_prev_d = GearNone;
              end

              if (s1_q.turn_code != TurnOff && s1_q.turn_code != turn_prev_q) begin
                turn_d = (seen_turn_q == s1_q.turn_code) ? TurnOff : s1_q.turn_code;
              end
              turn_prev_d = s1_q.turn_code;

              if (s1_q.cmd_uplink_button && !uplink_prev_q) begin
                uplink_d = !uplink_q;
              end
              uplink_prev_d = s1_q.cmd_uplink_button;
            end else begin
              gear_d        = GearPark;
              turn_d        = TurnOff;
              uplink_prev_d = 1'b0;
              uplink_d      = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end

    out_d.out_engage = engage_d;
    out_d.out_gear   = gear_d;
    out_d.out_turn   = turn_d;
    out_d.out_uplink = uplink_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tel_valid_q   <= 1'b0;
      seen_remote_q <= 1'b0;
      seen_vel_q    <= '0;
      seen_turn_q   <= TurnOff;
      seen_gear_q   <= GearNone;
      engage_q      <= 1'b0;
      engage_prev_q <= 1'b0;
      gear_q        <= GearPark;
      gear_prev_q   <= GearNone;
      turn_q        <= TurnOff;
      turn_prev_q   <= TurnOff;
      uplink_q      <= 1'b0;
      uplink_prev_q <= 1'b0;
      wd_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      tel_valid_q   <= tel_valid_d;
      seen_remote_q <= seen_remote_d;
      seen_vel_q    <= seen_vel_d;
      seen_turn_q   <= seen_turn_d;
      seen_gear_q   <= seen_gear_d;
      engage_q      <= engage_d;
      engage_prev_q <= engage_prev_d;
      gear_q        <= gear_d;
      gear_prev_q   <= gear_prev_d;
      turn_q        <= turn_d;
      turn_prev_q   <= turn_prev_d;
      uplink_q      <= uplink_d;
      uplink_prev_q <= uplink_prev_d;
      wd_q          <= wd_d;
      if (s1_adv && gives_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && gives_result) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // without telemetry the targets sit at their rest values
  a_rest_without_tel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tel_valid_q |-> (gear_q == GearPark && !engage_q && turn_q == TurnOff && !uplink_q))
    else $error("targets not at rest while telemetry is invalid");

  a_wd_below_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.func == FuncTick) |=> (wd_q < tmo_q || wd_q == '0))
    else $error("watchdog count left at or above timeout");

  a_tel_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.func == FuncTel) |=> tel_valid_q)
    else $error("telemetry item did not validate telemetry");

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (gives_result && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule
